>>> rtl/mpm_pkg.sv
// ----------------------------------------------------------------------------
// mpm_pkg: shared definitions for the modular matrix power block
// Sizes, modulus constants, cell control types and the controller states.
// ----------------------------------------------------------------------------
package mpm_pkg;

	localparam int MAX_DIM = 3;
	localparam int MODULUS = 10007;
	localparam int NC = MAX_DIM * MAX_DIM;
	localparam int MW = $clog2(MODULUS);
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int CW = (NC > 1) ? $clog2(NC) : 1;
	localparam int IW = $clog2(2 * MAX_DIM);
	localparam int AW = 2 * MW + $clog2(MAX_DIM + 1);
	localparam longint unsigned RECIP = (64'd1 << AW) / MODULUS;
	localparam int RW = $clog2(RECIP + 1);
	localparam int EXP_W = 31;
	localparam int ENT_W = 14;

	typedef struct packed {
		logic init;
		logic load;
		logic mul;
		logic red1;
		logic wr_res;
		logic wr_sq;
		logic x_res;
	} cell_ctl_t;

	typedef struct packed {
		logic ld;
		logic [DW-1:0] row;
		logic [DW-1:0] col;
		logic last;
	} emit_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_CHECK,
		ST_LOAD,
		ST_MUL,
		ST_DRAIN,
		ST_RED1,
		ST_RED2,
		ST_EMIT
	} state_t;

	function automatic logic [IW-1:0] wrap(input logic [IW-1:0] x, input logic [DW-1:0] d);
		logic [IW-1:0] y;
		y = (x >= IW'(d)) ? x - IW'(d) : x;
		if (y >= IW'(MAX_DIM)) begin
			y = '0;
		end
		return y;
	endfunction

endpackage

>>> rtl/mpm_cell.sv
// ----------------------------------------------------------------------------
// mpm_cell: one entry of the matrix grid
// Holds the base, square and result entries, rotates its operands to its
// neighbors, multiplies and accumulates, and reduces the sum modulo MODULUS.
// ----------------------------------------------------------------------------
module mpm_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mpm_pkg::cell_ctl_t     ctl,
	input  logic                   base_we,
	input  logic [mpm_pkg::MW-1:0] base_in,
	input  logic                   one,
	input  logic                   keep,
	input  logic [mpm_pkg::MW-1:0] a_ld,
	input  logic [mpm_pkg::MW-1:0] b_ld,
	input  logic [mpm_pkg::MW-1:0] a_nx,
	input  logic [mpm_pkg::MW-1:0] b_nx,
	output logic [mpm_pkg::MW-1:0] a,
	output logic [mpm_pkg::MW-1:0] b,
	output logic [mpm_pkg::MW-1:0] sq,
	output logic [mpm_pkg::MW-1:0] res
);
	import mpm_pkg::*;

	localparam logic [AW-1:0] MOD_AW = AW'(MODULUS);
	localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

	logic [MW-1:0] base_q, sq_q, res_q, a_q, b_q;
	logic [2*MW-1:0] prod_s1;
	logic pv_q;
	logic [AW-1:0] acc_q;
	logic [RW-1:0] qt_q;
	logic [AW+RW-1:0] pr;
	logic [AW-1:0] rm, red;

	always_comb begin
		pr = (AW+RW)'(acc_q) * (AW+RW)'(RECIP_V);
		rm = acc_q - AW'(qt_q) * MOD_AW;
		red = (rm >= MOD_AW) ? rm - MOD_AW : rm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			sq_q <= '0;
			res_q <= '0;
			pv_q <= 1'b0;
		end else begin
			if (base_we) begin
				base_q <= base_in;
			end
			if (ctl.init) begin
				res_q <= one ? MW'(1) : '0;
				sq_q <= keep ? base_q : '0;
			end
			if (ctl.wr_res) begin
				res_q <= red[MW-1:0];
			end
			if (ctl.wr_sq) begin
				sq_q <= red[MW-1:0];
			end
			if (ctl.load) begin
				pv_q <= 1'b0;
			end else begin
				pv_q <= ctl.mul;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= a_ld;
			b_q <= b_ld;
			acc_q <= '0;
		end else begin
			if (ctl.mul) begin
				a_q <= a_nx;
				b_q <= b_nx;
			end
			if (pv_q) begin
				acc_q <= acc_q + AW'(prod_s1);
			end
		end
		if (ctl.mul) begin
			prod_s1 <= (2*MW)'(a_q) * (2*MW)'(b_q);
		end
		if (ctl.red1) begin
			qt_q <= pr[AW+RW-1:AW];
		end
	end

	assign a = a_q;
	assign b = b_q;
	assign sq = sq_q;
	assign res = res_q;

endmodule

>>> rtl/mpm_ctrl.sv
// ----------------------------------------------------------------------------
// mpm_ctrl: sequencer for square-and-multiply
// Walks the exponent bits, runs each matrix product on the cell grid and
// steps through the result entries for output.
// ----------------------------------------------------------------------------
module mpm_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mpm_pkg::EXP_W-1:0] exponent,
	input  logic [mpm_pkg::DW-1:0]    dim,
	input  logic                      out_free,
	output logic                      idle,
	output mpm_pkg::cell_ctl_t        ctl,
	output mpm_pkg::emit_t            emit
);
	import mpm_pkg::*;

	state_t state_q, state_n;
	logic [EXP_W-1:0] e_q, e_n;
	logic sqph_q, sqph_n;
	logic [DW-1:0] k_q, k_n, er_q, er_n, ec_q, ec_n;
	logic [DW-1:0] dm1;

	assign dm1 = dim - DW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			e_q <= '0;
			sqph_q <= 1'b0;
			k_q <= '0;
			er_q <= '0;
			ec_q <= '0;
		end else begin
			state_q <= state_n;
			e_q <= e_n;
			sqph_q <= sqph_n;
			k_q <= k_n;
			er_q <= er_n;
			ec_q <= ec_n;
		end
	end

	always_comb begin
		state_n = state_q;
		e_n = e_q;
		sqph_n = sqph_q;
		k_n = k_q;
		er_n = er_q;
		ec_n = ec_q;
		ctl = '0;
		ctl.x_res = ~sqph_q;
		emit = '0;
		emit.row = er_q;
		emit.col = ec_q;
		emit.last = (er_q == dm1) && (ec_q == dm1);
		idle = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					e_n = exponent;
					state_n = ST_INIT;
				end
			end
			ST_INIT: begin
				ctl.init = 1'b1;
				state_n = ST_CHECK;
			end
			ST_CHECK: begin
				if (e_q == '0) begin
					er_n = '0;
					ec_n = '0;
					state_n = ST_EMIT;
				end else begin
					sqph_n = ~e_q[0];
					state_n = ST_LOAD;
				end
			end
			ST_LOAD: begin
				ctl.load = 1'b1;
				k_n = '0;
				state_n = ST_MUL;
			end
			ST_MUL: begin
				ctl.mul = 1'b1;
				k_n = k_q + DW'(1);
				if (k_q == dm1) begin
					state_n = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_n = ST_RED1;
			end
			ST_RED1: begin
				ctl.red1 = 1'b1;
				state_n = ST_RED2;
			end
			ST_RED2: begin
				ctl.wr_res = ~sqph_q;
				ctl.wr_sq = sqph_q;
				if (!sqph_q) begin
					sqph_n = 1'b1;
					state_n = ST_LOAD;
				end else begin
					e_n = e_q >> 1;
					state_n = ST_CHECK;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit.ld = 1'b1;
					if (ec_q == dm1) begin
						ec_n = '0;
						er_n = er_q + DW'(1);
					end else begin
						ec_n = ec_q + DW'(1);
					end
					if (emit.last) begin
						state_n = ST_IDLE;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/matrix_power_modular.sv
// ----------------------------------------------------------------------------
// matrix_power_modular: modular power of a small square matrix
// Grid of entry cells with Cannon-style operand rotation, driven by a
// square-and-multiply sequencer.
// ----------------------------------------------------------------------------
// A load item writes one base entry. A compute item with size d first
// initializes the grid, then for each exponent bit up to the highest set
// one checks the bit and runs the matrix products, two for a set bit and
// one for a clear bit; then d*d output items follow, one per cycle when
// the output is not stalled. The products run on the MAX_DIM*MAX_DIM grid
// of cells, each with its own multiplier, so one product needs loading,
// multiplying, draining and a modular reduction. No new item
// is taken until the last output item has been loaded.
module matrix_power_modular (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [1:0]  row_index,
	input  logic [1:0]  col_index,
	input  logic [13:0] entry_value,
	input  logic [30:0] exponent,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_row,
	output logic [1:0]  out_col,
	output logic [13:0] out_value,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data
);
	import mpm_pkg::*;

	localparam logic [ENT_W-1:0] ENT_MOD = ENT_W'(MODULUS);

	logic [1:0] size_q;
	logic [DW-1:0] dim;
	logic acc_in, idle, out_free;
	cell_ctl_t ctl;
	emit_t emit;
	logic [MW-1:0] base_in;
	logic [MW-1:0] a_w [NC];
	logic [MW-1:0] b_w [NC];
	logic [MW-1:0] sq_w [NC];
	logic [MW-1:0] res_w [NC];
	logic [CW-1:0] out_idx;
	logic out_valid_q, last_q;
	logic [1:0] out_row_q, out_col_q;
	logic [13:0] out_value_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 2'd3;
		end else if (cfg_valid) begin
			size_q <= cfg_data;
		end
	end

	always_comb begin
		if (size_q == 2'd0) begin
			dim = DW'(1);
		end else if (int'(size_q) > MAX_DIM) begin
			dim = DW'(MAX_DIM);
		end else begin
			dim = DW'(size_q);
		end
	end

	assign in_stall = ~idle;
	assign acc_in = in_valid & idle;
	assign out_free = ~out_valid_q | ~out_stall;
	assign base_in = MW'(entry_value >= ENT_MOD ? entry_value - ENT_MOD : entry_value);

	mpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (acc_in & mode),
		.exponent (exponent),
		.dim      (dim),
		.out_free (out_free),
		.idle     (idle),
		.ctl      (ctl),
		.emit     (emit)
	);

	for (genvar r = 0; r < MAX_DIM; r++) begin : g_row
		for (genvar c = 0; c < MAX_DIM; c++) begin : g_col
			logic [IW-1:0] sk, cn, rn;
			logic [MW-1:0] a_ld, b_ld, a_nx, b_nx;
			logic we, one, keep;

			always_comb begin
				sk = wrap(IW'(r + c), dim);
				cn = wrap(IW'(c + 1), dim);
				rn = wrap(IW'(r + 1), dim);
				a_ld = ctl.x_res ? res_w[CW'(r * MAX_DIM) + CW'(sk)]
						 : sq_w[CW'(r * MAX_DIM) + CW'(sk)];
				b_ld = sq_w[CW'(sk) * CW'(MAX_DIM) + CW'(c)];
				a_nx = a_w[CW'(r * MAX_DIM) + CW'(cn)];
				b_nx = b_w[CW'(rn) * CW'(MAX_DIM) + CW'(c)];
				we = acc_in & ~mode & (int'(row_index) == r) & (int'(col_index) == c);
				one = (r == c) && (DW'(r) < dim);
				keep = (DW'(r) < dim) && (DW'(c) < dim);
			end

			mpm_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.base_we (we),
				.base_in (base_in),
				.one     (one),
				.keep    (keep),
				.a_ld    (a_ld),
				.b_ld    (b_ld),
				.a_nx    (a_nx),
				.b_nx    (b_nx),
				.a       (a_w[r * MAX_DIM + c]),
				.b       (b_w[r * MAX_DIM + c]),
				.sq      (sq_w[r * MAX_DIM + c]),
				.res     (res_w[r * MAX_DIM + c])
			);
		end
	end

	assign out_idx = CW'(emit.row) * CW'(MAX_DIM) + CW'(emit.col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.ld) begin
			out_row_q <= 2'(emit.row);
			out_col_q <= 2'(emit.col);
			out_value_q <= 14'(res_w[out_idx]);
			last_q <= emit.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row = out_row_q;
	assign out_col = out_col_q;
	assign out_value = out_value_q;
	assign last = last_q;

	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> out_row == out_col)
		else $error("Last item is not on the diagonal.");

	a_emit_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("Gap inside the result item run.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode |=> in_stall)
		else $error("Compute item did not make the block busy.");

endmodule

>>> verif/tb_matrix_power_modular.sv
// ----------------------------------------------------------------------------
// tb_matrix_power_modular: self-checking testbench for the matrix power block
// A directed table of loads, powers and size changes comes first. Random
// traffic follows over four size phases, with one long output hold-off.
// Every accepted item updates a local model that queues the expected entries.
// Each emitted entry is compared with the oldest queued entry.
// ----------------------------------------------------------------------------
module tb_matrix_power_modular;
	import mpm_pkg::*;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_POWER = 1'b1;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 100;

	typedef enum int {K_LOAD, K_POWER, K_SIZE} row_kind_t;
	typedef int unsigned mat_t [NC];

	typedef struct {
		row_kind_t kind;
		logic [1:0] r;
		logic [1:0] c;
		logic [13:0] v;
		logic [30:0] e;
		int corner;
	} dir_row_t;

	typedef struct {
		logic [1:0] r;
		logic [1:0] c;
		logic [13:0] v;
		logic l;
	} entry_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic mode;
	logic [1:0] row_index;
	logic [1:0] col_index;
	logic [13:0] entry_value;
	logic [30:0] exponent;
	logic out_valid;
	logic out_stall;
	logic [1:0] out_row;
	logic [1:0] out_col;
	logic [13:0] out_value;
	logic last;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_data;

	mat_t base_m;
	logic [1:0] size_reg;
	entry_t pending_q[$];
	int corner_q[$];
	int mismatches;
	int in_idle_pct;
	int out_stall_pct;
	int hold_req;
	int powers_sent;
	int entries_seen;
	longint cycles;

	dir_row_t dir_rows[] = '{
		'{K_POWER, 2'd0, 2'd0, 14'd0, 31'd0, 1},
		'{K_POWER, 2'd0, 2'd0, 14'd0, 31'd5, 0},
		'{K_SIZE, 2'd0, 2'd0, 14'd1, 31'd0, -1},
		'{K_LOAD, 2'd0, 2'd0, 14'd10006, 31'd0, -1},
		'{K_POWER, 2'd0, 2'd0, 14'd0, 31'd1, 10006},
		'{K_POWER, 2'd0, 2'd0, 14'd0, 31'd2, 1},
		'{K_POWER, 2'd0, 2'd0, 14'd0, 31'h7FFFFFFF, 10006},
		'{K_LOAD, 2'd0, 2'd0, 14'h3FFF, 31'h7FFFFFFF, -1},
		'{K_POWER, 2'd0, 2'd0, 14'h3FFF, 31'd1, 6376},
		'{K_LOAD, 2'd3, 2'd0, 14'd5, 31'd0, -1},
		'{K_LOAD, 2'd0, 2'd3, 14'd7, 31'd0, -1},
		'{K_LOAD, 2'd3, 2'd3, 14'd9, 31'd0, -1},
		'{K_SIZE, 2'd0, 2'd0, 14'd0, 31'd0, -1},
		'{K_POWER, 2'd0, 2'd0, 14'd0, 31'd3, -1},
		'{K_SIZE, 2'd0, 2'd0, 14'd2, 31'd0, -1},
		'{K_LOAD, 2'd0, 2'd1, 14'd3, 31'd0, -1},
		'{K_LOAD, 2'd1, 2'd0, 14'd4, 31'd0, -1},
		'{K_LOAD, 2'd2, 2'd2, 14'd8, 31'd0, -1},
		'{K_POWER, 2'd0, 2'd0, 14'd0, 31'd7, -1},
		'{K_SIZE, 2'd0, 2'd0, 14'd3, 31'd0, -1},
		'{K_LOAD, 2'd2, 2'd1, 14'd10006, 31'd0, -1},
		'{K_POWER, 2'd0, 2'd0, 14'd0, 31'h7FFFFFFF, -1},
		'{K_POWER, 2'd0, 2'd0, 14'd0, 31'h55555555, -1}
	};

	matrix_power_modular dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.row_index(row_index),
		.col_index(col_index),
		.entry_value(entry_value),
		.exponent(exponent),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_row(out_row),
		.out_col(out_col),
		.out_value(out_value),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	function automatic mat_t mat_mul_mod(input mat_t x, input mat_t y, input int dim);
		mat_t z;
		longint unsigned acc;
		z = '{default: 0};
		for (int r = 0; r < dim; r++) begin
			for (int c = 0; c < dim; c++) begin
				acc = 0;
				for (int k = 0; k < dim; k++) begin
					acc = (acc + longint'(x[r*MAX_DIM+k]) * longint'(y[k*MAX_DIM+c])) % MODULUS;
				end
				z[r*MAX_DIM+c] = int'(acc);
			end
		end
		return z;
	endfunction

	function automatic void predict_item(input logic m, input logic [1:0] r, input logic [1:0] c,
			input logic [13:0] v, input logic [30:0] e, input int corner);
		int dim;
		mat_t acc_m;
		mat_t sq_m;
		logic [30:0] bits;
		entry_t ent;
		if (m == MODE_LOAD) begin
			if (r < MAX_DIM && c < MAX_DIM) begin
				base_m[r*MAX_DIM+c] = v % MODULUS;
			end
			return;
		end
		dim = (size_reg == 0) ? 1 : ((size_reg > MAX_DIM) ? MAX_DIM : size_reg);
		acc_m = '{default: 0};
		sq_m = '{default: 0};
		for (int i = 0; i < dim; i++) begin
			acc_m[i*MAX_DIM+i] = 1;
			for (int j = 0; j < dim; j++) begin
				sq_m[i*MAX_DIM+j] = base_m[i*MAX_DIM+j];
			end
		end
		bits = e;
		while (bits != 0) begin
			if (bits[0]) begin
				acc_m = mat_mul_mod(acc_m, sq_m, dim);
			end
			sq_m = mat_mul_mod(sq_m, sq_m, dim);
			bits = bits >> 1;
		end
		for (int i = 0; i < dim; i++) begin
			for (int j = 0; j < dim; j++) begin
				ent.r = 2'(i);
				ent.c = 2'(j);
				ent.v = 14'(acc_m[i*MAX_DIM+j]);
				ent.l = (i == dim - 1 && j == dim - 1);
				pending_q.push_back(ent);
			end
		end
		corner_q.push_back(corner);
		powers_sent++;
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch at cycle %0d: %s", cycles, msg);
		end
	endtask

	task automatic send_item(input logic m, input logic [1:0] r, input logic [1:0] c,
			input logic [13:0] v, input logic [30:0] e, input int corner);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode = m;
		row_index = r;
		col_index = c;
		entry_value = v;
		exponent = e;
		do begin
			@(posedge clk);
		end while (in_stall);
		predict_item(m, r, c, v, e, corner);
		@(negedge clk);
	endtask

	task automatic write_size(input logic [1:0] s);
		in_valid = 1'b0;
		while (pending_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = s;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		size_reg = s;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data = 2'($urandom);
	endtask

	task automatic random_item();
		int pick;
		logic [13:0] v;
		logic [30:0] e;
		pick = $urandom_range(99);
		v = ($urandom_range(9) < 8) ? 14'($urandom_range(MODULUS - 1)) : 14'($urandom);
		if (pick < 80) begin
			e = 31'($urandom_range(40));
		end else if (pick < 95) begin
			e = 31'($urandom_range(65535));
		end else begin
			e = 31'($urandom);
		end
		pick = $urandom_range(99);
		if (pick < 70) begin
			send_item(MODE_LOAD, 2'($urandom_range(2)), 2'($urandom_range(2)), v, e, -1);
		end else if (pick < 78) begin
			send_item(MODE_LOAD, 2'($urandom), 2'd3 - 2'($urandom_range(1)), v, e, -1);
		end else begin
			send_item(MODE_POWER, 2'($urandom), 2'($urandom), v, e, -1);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("[matrix_power_modular] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold = hold_req;
				hold_req = 0;
			end
			if (hold > 0) begin
				out_stall = 1'b1;
				hold--;
			end else begin
				out_stall = ($urandom_range(99) < out_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		entry_t want;
		int corner;
		if (arst_n && out_valid && !out_stall) begin
			entries_seen++;
			if (pending_q.size() == 0) begin
				flag_error($sformatf("unexpected entry r%0d c%0d v%0d last %0d",
					out_row, out_col, out_value, last));
			end else begin
				want = pending_q.pop_front();
				if (out_row !== want.r || out_col !== want.c || out_value !== want.v
						|| last !== want.l) begin
					flag_error($sformatf("expected r%0d c%0d v%0d last %0d, got r%0d c%0d v%0d last %0d",
						want.r, want.c, want.v, want.l, out_row, out_col, out_value, last));
				end
				if (want.l && corner_q.size() != 0) begin
					corner = corner_q.pop_front();
					if (corner >= 0 && out_value !== 14'(corner)) begin
						flag_error($sformatf("corner entry expected %0d, got %0d", corner, out_value));
					end
				end
			end
		end
	end

	initial begin
		logic [1:0] sizes [4];
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_LOAD;
		row_index = '0;
		col_index = '0;
		entry_value = '0;
		exponent = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		hold_req = 0;
		powers_sent = 0;
		entries_seen = 0;
		base_m = '{default: 0};
		size_reg = 2'd3;
		sizes = '{2'd1, 2'd2, 2'd3, 2'd0};
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				K_SIZE: write_size(dir_rows[i].v[1:0]);
				K_LOAD: send_item(MODE_LOAD, dir_rows[i].r, dir_rows[i].c, dir_rows[i].v,
					dir_rows[i].e, -1);
				default: send_item(MODE_POWER, dir_rows[i].r, dir_rows[i].c, dir_rows[i].v,
					dir_rows[i].e, dir_rows[i].corner);
			endcase
		end

		for (int phase = 0; phase < 4; phase++) begin
			write_size(sizes[phase]);
			in_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 27 : 55) : 0;
			out_stall_pct = (phase == 2) ? 55 : ((phase == 3) ? 27 : 0);
			for (int n = 0; n < 120; n++) begin
				if (phase == 2 && n == 40) begin
					hold_req = HOLD_CYCLES;
				end
				random_item();
			end
		end
		in_valid = 1'b0;

		while (pending_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Covered %0d power items and %0d result entries over sizes 0 to 3,",
			powers_sent, entries_seen);
		$display("with exponents up to 31 bits, unreduced and out-of-range loads, and stalls.");
		if (mismatches == 0 && pending_q.size() == 0) begin
			$display("[matrix_power_modular] OK");
		end else begin
			$display("[matrix_power_modular] ERROR");
		end
		$finish;
	end

endmodule
